>>> hw/rtl/dlps_pkg.sv
package dlps_pkg;

   // Store and sine table depths are powers of two.
   localparam int STORE_DEPTH = 65536;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int FRAC_W      = 8;
   localparam int POS_W       = STORE_AW + FRAC_W;
   localparam int SINE_DEPTH  = 1024;
   localparam int SINE_AW     = $clog2(SINE_DEPTH);
   localparam int SAMPLE_W    = 24;
   localparam int PHASE_W     = 32;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int OUTQ_DEPTH  = 4;
   localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);
   localparam int STEP_W      = 10;

   localparam int LOCK_DELAY  = 2000;
   localparam int GAP_LIMIT   = 100;

   localparam logic [MODE_W-1:0] MODE_DEEP  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIGH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RING  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNITY = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_VOICE_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_STEP  = 1'b1;

   localparam logic [MODE_W-1:0]  VOICE_MODE_RESET = MODE_UNITY;
   localparam logic [PHASE_W-1:0] RING_STEP_RESET  = 32'd4473924;

   // Position increments in 1/256 sample.
   localparam logic [STEP_W-1:0] STEP_DEEP  = 10'd192;
   localparam logic [STEP_W-1:0] STEP_HIGH  = 10'd384;
   localparam logic [STEP_W-1:0] STEP_UNITY = 10'd256;

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] Q23_MAX    = 64'd8388607;

   typedef logic [STORE_AW-1:0]        addr_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SINE_AW-1:0]         sine_addr_type;
   typedef logic signed [SAMPLE_W-1:0] sine_tab_type [SINE_DEPTH];

   typedef struct packed {
      logic       wr_en;
      addr_type   wr_addr;
      sample_type wr_data;
      addr_type   rd_addr;
   } store_req_type;

   // Sine in Q1.23 from a Taylor series on a folded Q30 angle, evaluated at elaboration.
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0]  t;
      logic [63:0]  r;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [1:0]   quad;
      sample_type   v;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         t    = 64'(k) << (32 - SINE_AW);
         quad = t[31:30];
         r    = {34'd0, t[29:0]};
         if (quad[0]) begin
            r = (64'd1 << 30) - r;
         end
         x    = (r * TWO_PI_Q30) >> 32;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd210;
         sum  = sum - term;
         sum  = (sum + 64'd64) >> 7;
         if (sum > Q23_MAX) begin
            sum = Q23_MAX;
         end
         v      = sample_type'(sum[SAMPLE_W-1:0]);
         tab[k] = quad[1] ? -v : v;
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

>>> hw/rtl/dlps_store.sv
module dlps_store (
   input  logic                   clock,
   input  dlps_pkg::store_req_type req,
   output dlps_pkg::sample_type   rd_data
);
   import dlps_pkg::*;

   sample_type mem [STORE_DEPTH];
   sample_type rd_data_ff;

   // Read returns the old contents when the same entry is written in that cycle.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= mem[req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/dlps_sine_rom.sv
module dlps_sine_rom (
   input  logic                    clock,
   input  logic                    rd_en,
   input  dlps_pkg::sine_addr_type rd_addr,
   output dlps_pkg::sample_type    rd_data
);
   import dlps_pkg::*;

   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_TAB[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/dlps_out_queue.sv
module dlps_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dlps_pkg::sample_type push_data,
   input  logic                 pop,
   output logic                 valid,
   output dlps_pkg::sample_type data
);
   import dlps_pkg::*;

   sample_type           entry_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]   wr_ptr_ff;
   logic [OUTQ_AW-1:0]   wr_ptr_in;
   logic [OUTQ_AW-1:0]   rd_ptr_ff;
   logic [OUTQ_AW-1:0]   rd_ptr_in;
   logic [OUTQ_AW:0]     count_ff;
   logic [OUTQ_AW:0]     count_in;
   logic                 do_pop;

   assign valid  = (count_ff != '0);
   assign data   = entry_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (OUTQ_AW+1)'(push) - (OUTQ_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/delay_line_pitch_shift_ring_mod.sv
// Channel  | Direction | Signals                        | Payload
// req      | in        | req_tvalid/tready/tdata[23:0]  | sample_in (signed Q1.23)
// rsp      | out       | rsp_tvalid/tready/tdata[23:0]  | sample_out (signed Q1.23)
// csr      | in        | csr_we/index[0:0]/wdata[31:0]  | 0 voice_mode, 1 ring_phase_step
//
// Transactions are not taken back to back: the store has one read port, and the two
// interpolation neighbors are read in consecutive cycles. A result passes the p1, p2 and
// p3 registers and the output queue before it shows on rsp. Reset is synchronous; the store
// needs no clearing pass, as entries beyond the write index read as zero until the index
// first wraps. A 4-entry output queue absorbs rsp stalls; req_tready is low in the cycle
// after each transaction, during reset and while 4 transactions are outstanding.
module delay_line_pitch_shift_ring_mod (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [23:0]                           req_tdata,   // [23:0] sample_in
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [23:0]                           rsp_tdata,   // [23:0] sample_out
   input  logic                                  csr_we,
   input  logic [dlps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dlps_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import dlps_pkg::*;

   localparam logic [1:0] SEL_MEM  = 2'd0;
   localparam logic [1:0] SEL_FWD  = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;

   localparam logic [POS_W:0]   SPAN   = (POS_W+1)'(STORE_DEPTH) << FRAC_W;
   localparam logic [POS_W-1:0] GAP_LO = POS_W'(GAP_LIMIT) << FRAC_W;
   localparam logic [POS_W-1:0] GAP_HI = POS_W'(STORE_DEPTH - GAP_LIMIT) << FRAC_W;
   localparam int               PROD_W = 2 * (SAMPLE_W + 1);

   function automatic sample_type pick(input logic [1:0] sel, input sample_type mem_val,
                                       input sample_type fwd_val);
      sample_type v;
      unique case (sel)
         SEL_MEM:  v = mem_val;
         SEL_FWD:  v = fwd_val;
         default:  v = '0;
      endcase
      return v;
   endfunction

   // Configuration and block state
   logic [MODE_W-1:0]  mode_ff;
   logic [PHASE_W-1:0] ring_step_ff;
   addr_type           wi_ff;
   addr_type           wi_in;
   logic               filled_ff;
   logic               filled_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [OUTQ_AW:0]   occ_ff;
   logic [OUTQ_AW:0]   occ_in;

   // Pipeline
   logic               p1_valid_ff;
   logic               p1_ring_ff;
   sample_type         p1_x_ff;
   logic [FRAC_W-1:0]  p1_frac_ff;
   addr_type           p1_ip1_ff;
   logic [1:0]         p1_sel1_ff;
   logic [1:0]         p1_sel2_ff;
   logic               p2_valid_ff;
   logic               p2_ring_ff;
   sample_type         p2_x_ff;
   logic [FRAC_W-1:0]  p2_frac_ff;
   logic [1:0]         p2_sel2_ff;
   sample_type         p2_s1_ff;
   logic               p3_valid_ff;
   logic               p3_ring_ff;
   logic signed [PROD_W-1:0] p3_prod_ff;
   sample_type         p3_s1_ff;

   logic               acc;
   logic               rsp_take;
   sample_type         x;
   addr_type           ip;
   addr_type           ip1;
   addr_type           lock_addr;
   logic [STEP_W-1:0]  step;
   logic [POS_W:0]     pos_sum;
   logic [POS_W-1:0]   pos_adv;
   logic [POS_W:0]     gap_raw;
   logic [POS_W:0]     gap_fix;
   logic [POS_W-1:0]   gap;
   logic               near;
   logic [1:0]         sel1;
   logic [1:0]         sel2;
   store_req_type      store_req;
   sample_type         store_rd;
   sample_type         sine_q;
   sample_type         s2;
   logic signed [SAMPLE_W:0] mul_a;
   logic signed [SAMPLE_W:0] mul_b;
   logic signed [PROD_W-1:0] prod;
   sample_type         y;

   assign req_tready = !reset && !p1_valid_ff && (occ_ff < (OUTQ_AW+1)'(OUTQ_DEPTH));
   assign acc        = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign x          = sample_type'(req_tdata);

   // Address and position update for the transaction taken in this cycle.
   always_comb begin
      ip  = pos_ff[POS_W-1:FRAC_W];
      ip1 = (ip == addr_type'(STORE_DEPTH - 1)) ? '0 : ip + 1'b1;
      if (wi_ff >= addr_type'(LOCK_DELAY)) begin
         lock_addr = wi_ff - addr_type'(LOCK_DELAY);
      end else begin
         lock_addr = wi_ff + addr_type'(STORE_DEPTH - LOCK_DELAY);
      end

      unique case (mode_ff)
         MODE_DEEP: step = STEP_DEEP;
         MODE_HIGH: step = STEP_HIGH;
         default:   step = STEP_UNITY;
      endcase

      pos_sum = {1'b0, pos_ff} + (POS_W+1)'(step);
      pos_adv = (pos_sum >= SPAN) ? POS_W'(pos_sum - SPAN) : pos_sum[POS_W-1:0];
      gap_raw = {1'b0, wi_ff, {FRAC_W{1'b0}}} - {1'b0, pos_adv};
      gap_fix = gap_raw[POS_W] ? gap_raw + SPAN : gap_raw;
      gap     = gap_fix[POS_W-1:0];
      near    = (gap < GAP_LO) || (gap > GAP_HI);

      unique case (mode_ff)
         MODE_RING:  pos_in = pos_ff;
         MODE_UNITY: pos_in = {lock_addr, {FRAC_W{1'b0}}};
         default:    pos_in = near ? {lock_addr, {FRAC_W{1'b0}}} : pos_adv;
      endcase
      if (!acc) begin
         pos_in = pos_ff;
      end

      // The sample written now is seen by this transaction's reads; entries past the write
      // index read as zero until the index has wrapped once.
      if (ip == wi_ff) begin
         sel1 = SEL_FWD;
      end else if (filled_ff || (ip < wi_ff)) begin
         sel1 = SEL_MEM;
      end else begin
         sel1 = SEL_ZERO;
      end
      if (ip1 == wi_ff) begin
         sel2 = SEL_FWD;
      end else if (filled_ff || (ip1 < wi_ff)) begin
         sel2 = SEL_MEM;
      end else begin
         sel2 = SEL_ZERO;
      end

      phase_in  = (acc && (mode_ff == MODE_RING)) ? phase_ff + ring_step_ff : phase_ff;
      wi_in     = acc ? ((wi_ff == addr_type'(STORE_DEPTH - 1)) ? '0 : wi_ff + 1'b1) : wi_ff;
      filled_in = filled_ff || (acc && (wi_ff == addr_type'(STORE_DEPTH - 1)));
      occ_in    = occ_ff + (OUTQ_AW+1)'(acc) - (OUTQ_AW+1)'(rsp_take);
   end

   always_comb begin
      store_req.wr_en   = acc;
      store_req.wr_addr = wi_ff;
      store_req.wr_data = x;
      store_req.rd_addr = p1_valid_ff ? p1_ip1_ff : ip;
   end

   dlps_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (store_rd)
   );

   dlps_sine_rom u_sine_rom (
      .clock   (clock),
      .rd_en   (acc),
      .rd_addr (phase_ff[PHASE_W-1 -: SINE_AW]),
      .rd_data (sine_q)
   );

   // One shared multiplier: ring product or fraction times neighbor difference.
   always_comb begin
      s2 = pick(p2_sel2_ff, store_rd, p2_x_ff);
      if (p2_ring_ff) begin
         mul_a = (SAMPLE_W+1)'(p2_x_ff);
         mul_b = (SAMPLE_W+1)'(sine_q);
      end else begin
         mul_a = (SAMPLE_W+1)'(s2) - (SAMPLE_W+1)'(p2_s1_ff);
         mul_b = {{(SAMPLE_W+1-FRAC_W){1'b0}}, p2_frac_ff};
      end
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);

      if (p3_ring_ff) begin
         y = sample_type'(p3_prod_ff[23 +: SAMPLE_W]);
      end else begin
         y = p3_s1_ff + sample_type'(p3_prod_ff[FRAC_W +: SAMPLE_W]);
      end
   end

   dlps_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (p3_valid_ff),
      .push_data (y),
      .pop       (rsp_tready),
      .valid     (rsp_tvalid),
      .data      (rsp_tdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= VOICE_MODE_RESET;
         ring_step_ff <= RING_STEP_RESET;
         wi_ff        <= '0;
         filled_ff    <= 1'b0;
         pos_ff       <= '0;
         phase_ff     <= '0;
         occ_ff       <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_VOICE_MODE: mode_ff      <= csr_wdata[MODE_W-1:0];
               CSR_RING_STEP:  ring_step_ff <= csr_wdata[PHASE_W-1:0];
            endcase
         end
         wi_ff       <= wi_in;
         filled_ff   <= filled_in;
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         occ_ff      <= occ_in;
         p1_valid_ff <= acc;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         p1_ring_ff <= (mode_ff == MODE_RING);
         p1_x_ff    <= x;
         p1_frac_ff <= pos_ff[FRAC_W-1:0];
         p1_ip1_ff  <= ip1;
         p1_sel1_ff <= sel1;
         p1_sel2_ff <= sel2;
      end
      if (p1_valid_ff) begin
         p2_ring_ff <= p1_ring_ff;
         p2_x_ff    <= p1_x_ff;
         p2_frac_ff <= p1_frac_ff;
         p2_sel2_ff <= p1_sel2_ff;
         p2_s1_ff   <= pick(p1_sel1_ff, store_rd, p1_x_ff);
      end
      if (p2_valid_ff) begin
         p3_ring_ff <= p2_ring_ff;
         p3_prod_ff <= prod;
         p3_s1_ff   <= p2_s1_ff;
      end
   end

endmodule

>>> hw/rtl/dlps_checker.sv
module dlps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // Requests are never taken back to back.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken in consecutive cycles");

   // Every taken request is followed by rsp_tvalid on the port.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##4 rsp_tvalid)
      else $error("response missing four cycles after request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind delay_line_pitch_shift_ring_mod dlps_checker u_dlps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
